// ===== rtl/cfr_pkg.sv =====
`timescale 1ns / 1ps

package cfr_pkg;

	// Largest frame, in bytes, that is accepted without an error.
	localparam int unsigned MAX_FRAME_BYTES = 1024;

	localparam int unsigned POS_W = 11;
	localparam int unsigned CNT_W = POS_W + 1;

	localparam logic [POS_W-1:0] POS_MAX       = '1;
	localparam logic [POS_W-1:0] HDR_BYTES     = POS_W'(5);
	localparam logic [7:0]       SUBFRAME_TYPE = 8'd8;
	localparam logic [3:0]       SUB_ID        = 4'd6;
	localparam logic [3:0]       SUB_LEN       = 4'd8;
	localparam logic [15:0]      SUM_GOOD      = 16'hFFFF;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_beat_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic        checksum_ok;
		logic        frame_error;
		logic [7:0]  version_field;
		logic [7:0]  frame_type;
		logic [15:0] port_field;
		logic [7:0]  payload_length;
		logic [3:0]  sub_type;
		logic [13:0] source_port;
		logic [13:0] destination_port;
		logic [31:0] sub_value;
	} result_beat_t;

endpackage

// ===== rtl/checksummed_frame_receiver.sv =====
`timescale 1ns / 1ps

// Checksummed frame receiver. Each input beat carries one byte of a datagram,
// with last_byte set on its final byte. Header bytes 0 to 4 are version,
// type, a little-endian 16-bit port and the payload length; every payload
// byte that arrives before the final byte leaves as a payload result, and the
// final byte produces one summary result instead, holding the ones'-
// complement checksum verdict (folded 16-bit sum of little-endian byte pairs
// equal to 0xFFFF), a frame error flag, the header fields and, for frame type
// 8, the unpacked sub-frame header. Header bytes that never arrived read as
// zero. The block takes one beat per clock while results are taken: a beat is
// registered in an input stage, and a single pass of small logic (one 16-bit
// add with end-around carry and some byte steering) then updates the frame
// state and loads the result register once that register is free. Result
// valid rises when the result register is loaded. Throughput is one byte per
// cycle as long as results are taken; a byte that is not payload and not
// final produces no result. After a summary the frame state returns to its
// reset values, ready for the next frame with no gap.

module checksummed_frame_receiver import cfr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  item_beat_t   item,
	output logic         result_valid,
	input  logic         result_ready,
	output result_beat_t result
);

	// Input stage.
	logic       valid_s1;
	item_beat_t item_s1;

	// Frame state.
	logic [POS_W-1:0] pos_q;
	logic [15:0]      sum_q;
	logic [7:0]       low_q;
	logic [39:0]      hdr_q;
	logic [31:0]      sub_hdr_q;
	logic [31:0]      sub_val_q;
	logic             err_q;

	// Result register.
	logic         res_valid_q;
	result_beat_t res_q;

	// The processing stage may fire whenever the result register is empty or
	// is being emptied in this cycle.
	logic advance;
	assign advance    = !res_valid_q || result_ready;
	assign item_ready = !valid_s1 || advance;

	logic fire;
	assign fire = valid_s1 && advance;

	// Next-state values for the byte held in the input stage.
	logic [POS_W-1:0] pos_n;
	logic [15:0]      sum_n;
	logic [7:0]       low_n;
	logic [39:0]      hdr_n;
	logic [31:0]      sub_hdr_n;
	logic [31:0]      sub_val_n;
	logic             err_n;
	logic [CNT_W-1:0] count;
	logic [POS_W-1:0] off;
	logic             in_payload;
	logic [16:0]      sum_wide;
	logic [7:0]       len;
	logic [7:0]       ftype;
	logic [7:0]       sb0, sb1, sb2, sb3;
	logic             frame_bad;
	logic             emit;
	result_beat_t     res_n;

	always_comb begin
		hdr_n      = hdr_q;
		sub_hdr_n  = sub_hdr_q;
		sub_val_n  = sub_val_q;
		low_n      = low_q;
		sum_n      = sum_q;
		in_payload = 1'b0;
		count      = {1'b0, pos_q} + CNT_W'(1);
		off        = pos_q - HDR_BYTES;
		len        = hdr_q[39:32];

		// Header capture, then payload capture of the first eight payload
		// bytes for the sub-frame fields. The length byte is already stored
		// by the time the first payload byte arrives.
		if (pos_q < HDR_BYTES) begin
			hdr_n[{pos_q[2:0], 3'b000} +: 8] = item_s1.data_byte;
		end else if (off < {3'b000, len}) begin
			in_payload = 1'b1;
			if (off < POS_W'(4)) begin
				sub_hdr_n[{off[1:0], 3'b000} +: 8] = item_s1.data_byte;
			end else if (off < POS_W'(8)) begin
				sub_val_n[{off[1:0], 3'b000} +: 8] = item_s1.data_byte;
			end
		end

		// Ones'-complement accumulation over little-endian byte pairs. The
		// fold cannot carry a second time since both operands are 16 bits.
		sum_wide = {1'b0, sum_q} + {1'b0, item_s1.data_byte, low_q};
		if (!pos_q[0]) begin
			low_n = item_s1.data_byte;
		end else if (sum_wide[16]) begin
			sum_n = sum_wide[15:0] + 16'd1;
		end else begin
			sum_n = sum_wide[15:0];
		end

		err_n = err_q || (count > CNT_W'(MAX_FRAME_BYTES));
		pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);

		// Summary fields are taken from the state including this byte.
		ftype = hdr_n[15:8];
		sb0   = sub_hdr_n[7:0];
		sb1   = sub_hdr_n[15:8];
		sb2   = sub_hdr_n[23:16];
		sb3   = sub_hdr_n[31:24];

		frame_bad = err_n || count[0] ||
			(count < {1'b0, HDR_BYTES}) ||
			(count < ({1'b0, HDR_BYTES} + {4'b0000, hdr_n[39:32]}));

		res_n = '0;
		if (item_s1.last_byte) begin
			res_n.kind           = KIND_SUMMARY;
			res_n.checksum_ok    = (sum_n == SUM_GOOD);
			res_n.frame_error    = frame_bad;
			res_n.version_field  = hdr_n[7:0];
			res_n.frame_type     = ftype;
			res_n.port_field     = hdr_n[31:16];
			res_n.payload_length = hdr_n[39:32];
			if (ftype == SUBFRAME_TYPE) begin
				res_n.sub_type         = sb0[3:0];
				res_n.source_port      = {sb2[1:0], sb1, sb0[7:4]};
				res_n.destination_port = {sb3, sb2[7:2]};
				if (sb0[3:0] == SUB_ID) begin
					res_n.sub_value = sub_val_n;
				end else if (sb0[3:0] == SUB_LEN) begin
					res_n.sub_value = {24'd0, sub_val_n[7:0]};
				end
			end
		end else begin
			res_n.kind         = KIND_PAYLOAD;
			res_n.payload_byte = item_s1.data_byte;
		end

		emit = item_s1.last_byte || in_payload;
	end

	// Input stage: the control bit resets, the byte itself does not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// Frame state. A summary returns every field to its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sum_q     <= '0;
			low_q     <= '0;
			hdr_q     <= '0;
			sub_hdr_q <= '0;
			sub_val_q <= '0;
			err_q     <= 1'b0;
		end else if (fire) begin
			if (item_s1.last_byte) begin
				pos_q     <= '0;
				sum_q     <= '0;
				low_q     <= '0;
				hdr_q     <= '0;
				sub_hdr_q <= '0;
				sub_val_q <= '0;
				err_q     <= 1'b0;
			end else begin
				pos_q     <= pos_n;
				sum_q     <= sum_n;
				low_q     <= low_n;
				hdr_q     <= hdr_n;
				sub_hdr_q <= sub_hdr_n;
				sub_val_q <= sub_val_n;
				err_q     <= err_n;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_q <= res_n;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
